>>> sv/mrkcl_pkg.sv
// Shared constants, codes and controller/datapath interface types for the
// multi-room keypad code lock. No dependencies; imported by every module.
`timescale 1ns / 1ps
package mrkcl_pkg;

  // Table geometry
  localparam int ROOM_COUNT  = 16;
  localparam int CODE_LENGTH = 4;
  localparam int SLOT_W      = (ROOM_COUNT > 1) ? $clog2(ROOM_COUNT) : 1;
  localparam int CODE_W      = 8 * CODE_LENGTH;
  localparam int KEY_CNT_W   = $clog2(CODE_LENGTH) + 1;
  localparam int CFG_W       = 32;
  localparam int OUT_DATA_W  = 16;

  localparam logic [CFG_W-1:0] DEFAULT_CODE_RST = 32'h3737_3737;

  // Item kinds (in_tuser)
  localparam logic KIND_SERIAL = 1'b0;
  localparam logic KIND_KEY    = 1'b1;

  // Key character meaning no key pressed
  localparam logic [7:0] NO_KEY = 8'h78;

  // Command bytes
  localparam logic [1:0] CMD_EMPTY   = 2'd0;
  localparam logic [1:0] CMD_RESERVE = 2'd1;
  localparam logic [1:0] CMD_CLEAN   = 2'd2;
  localparam logic [7:0] CMD_MAX     = 8'd2;

  // Indicator writes
  localparam logic [1:0] LED_NONE = 2'd0;
  localparam logic [1:0] LED_RED  = 2'd1;
  localparam logic [1:0] LED_BLUE = 2'd2;

  // Room states
  localparam logic [1:0] ROOM_EMPTY    = 2'd0;
  localparam logic [1:0] ROOM_RESERVED = 2'd1;
  localparam logic [1:0] ROOM_CLEANING = 2'd2;

  // Error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_NO_ROOM  = 2'd1;
  localparam logic [1:0] ERR_BAD_CMD  = 2'd2;

  // Lock phase, reported on the result word
  typedef enum logic [2:0] {
    PH_LOAD   = 3'd0,
    PH_CMD    = 3'd1,
    PH_ROOM   = 3'd2,
    PH_NEW    = 3'd3,
    PH_VERIFY = 3'd4
  } phase_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic              capture;   // latch the input word and room match vector
    logic              commit;    // load the result register
    logic              load_en;   // write one table slot during loading
    logic [SLOT_W-1:0] load_idx;
    logic              sel_found; // current slot takes the lookup result
    logic              rs_wr;     // room state write at the new current slot
    logic [1:0]        rs_val;
    logic              ro_wr;     // open flag write at the new current slot
    logic              ro_val;
    logic              key_shift; // shift the key into the entry buffer
    logic              entry_clr; // clear the entry buffer
    logic              code_wr;   // store the shifted entry as the room code
    logic [1:0]        led;
    logic [1:0]        err;
    phase_t            phase;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic       found;      // room number matched some slot
    logic       code_match; // shifted entry equals the current room code
    logic       out_free;   // result register can take a word
  } dp_sts_t;

endpackage

>>> sv/mrkcl_ctrl.sv
// Controller for the keypad code lock: item handshake sequencer and lock
// phase logic. Depends on mrkcl_pkg; drives mrkcl_dp through dp_cmd_t.
`timescale 1ns / 1ps
module mrkcl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  mrkcl_pkg::dp_sts_t sts,
  output mrkcl_pkg::dp_cmd_t cmd
);
  import mrkcl_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } fsm_t;

  fsm_t                 state_r, state_nxt;
  phase_t               phase_r, phase_nxt;
  logic [SLOT_W-1:0]    load_cnt_r, load_cnt_nxt;
  logic [1:0]           pend_r, pend_nxt;
  logic [KEY_CNT_W-1:0] key_cnt_r, key_cnt_nxt;

  assign in_tready = (state_r == ST_IDLE);

  // Sequence: take a word in IDLE, apply it in EXEC once the result slot frees
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Lock phase decisions for the captured word
  always_comb begin
    cmd          = '0;
    cmd.phase    = phase_r;
    cmd.led      = LED_NONE;
    cmd.err      = ERR_NONE;
    cmd.capture  = in_tvalid && in_tready;
    cmd.load_idx = load_cnt_r;
    phase_nxt    = phase_r;
    load_cnt_nxt = load_cnt_r;
    pend_nxt     = pend_r;
    key_cnt_nxt  = key_cnt_r;

    if (state_r == ST_EXEC && sts.out_free) begin
      cmd.commit = 1'b1;
      unique case (phase_r)
        PH_LOAD: begin
          if (sts.kind == KIND_SERIAL) begin
            cmd.load_en  = 1'b1;
            cmd.rs_wr    = 1'b1;
            cmd.rs_val   = ROOM_EMPTY;
            cmd.ro_wr    = 1'b1;
            cmd.ro_val   = 1'b0;
            load_cnt_nxt = load_cnt_r + 1'b1;
            if (load_cnt_r == SLOT_W'(ROOM_COUNT - 1)) phase_nxt = PH_CMD;
          end
        end
        PH_CMD: begin
          if (sts.kind == KIND_SERIAL) begin
            if (sts.data_byte <= CMD_MAX) begin
              pend_nxt  = sts.data_byte[1:0];
              phase_nxt = PH_ROOM;
            end else begin
              cmd.err = ERR_BAD_CMD;
            end
          end
        end
        PH_ROOM: begin
          if (sts.kind == KIND_SERIAL) begin
            if (!sts.found) begin
              cmd.err   = ERR_NO_ROOM;
              phase_nxt = PH_CMD;
            end else begin
              cmd.sel_found = 1'b1;
              case (pend_r)
                CMD_EMPTY: begin
                  cmd.rs_wr  = 1'b1;
                  cmd.rs_val = ROOM_EMPTY;
                  cmd.ro_wr  = 1'b1;
                  cmd.ro_val = 1'b0;
                  cmd.led    = LED_RED;
                  phase_nxt  = PH_CMD;
                end
                CMD_CLEAN: begin
                  cmd.rs_wr  = 1'b1;
                  cmd.rs_val = ROOM_CLEANING;
                  cmd.ro_wr  = 1'b1;
                  cmd.ro_val = 1'b1;
                  cmd.led    = LED_BLUE;
                  phase_nxt  = PH_CMD;
                end
                default: begin
                  cmd.entry_clr = 1'b1;
                  key_cnt_nxt   = '0;
                  phase_nxt     = PH_NEW;
                end
              endcase
            end
          end
        end
        PH_NEW, PH_VERIFY: begin
          if (sts.kind == KIND_KEY && sts.data_byte != NO_KEY) begin
            cmd.key_shift = 1'b1;
            if (key_cnt_r == KEY_CNT_W'(CODE_LENGTH - 1)) begin
              // Group complete: store or compare, then start a new group
              key_cnt_nxt   = '0;
              cmd.entry_clr = 1'b1;
              if (phase_r == PH_NEW) begin
                cmd.code_wr = 1'b1;
                cmd.rs_wr   = 1'b1;
                cmd.rs_val  = ROOM_RESERVED;
                cmd.ro_wr   = 1'b1;
                cmd.ro_val  = 1'b0;
                cmd.led     = LED_RED;
                phase_nxt   = PH_VERIFY;
              end else if (sts.code_match) begin
                cmd.ro_wr  = 1'b1;
                cmd.ro_val = 1'b1;
                cmd.led    = LED_BLUE;
                phase_nxt  = PH_CMD;
              end
            end else begin
              key_cnt_nxt = key_cnt_r + 1'b1;
            end
          end
        end
        default: phase_nxt = PH_LOAD;
      endcase
      cmd.phase = phase_nxt;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      phase_r    <= PH_LOAD;
      load_cnt_r <= '0;
      pend_r     <= CMD_EMPTY;
      key_cnt_r  <= '0;
    end else begin
      state_r    <= state_nxt;
      phase_r    <= phase_nxt;
      load_cnt_r <= load_cnt_nxt;
      pend_r     <= pend_nxt;
      key_cnt_r  <= key_cnt_nxt;
    end
  end

endmodule

>>> sv/mrkcl_dp.sv
// Datapath for the keypad code lock: room tables, room lookup, entry buffer,
// default code register and result register. Depends on mrkcl_pkg.
`timescale 1ns / 1ps
module mrkcl_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_kind,
  input  logic [7:0]                   in_byte,
  input  logic                         cfg_wr_en,
  input  logic [mrkcl_pkg::CFG_W-1:0]  cfg_wr_data,
  input  logic                         out_tready,
  output logic                         out_tvalid,
  output logic [mrkcl_pkg::OUT_DATA_W-1:0] out_tdata,
  input  mrkcl_pkg::dp_cmd_t           cmd,
  output mrkcl_pkg::dp_sts_t           sts
);
  import mrkcl_pkg::*;

  localparam int CFG_EXT_W = (CODE_W > CFG_W) ? CODE_W : CFG_W;

  logic [7:0]            room_num_r  [ROOM_COUNT];
  logic [CODE_W-1:0]     room_code_r [ROOM_COUNT];
  logic [1:0]            room_st_r   [ROOM_COUNT];
  logic                  room_open_r [ROOM_COUNT];
  logic [CFG_W-1:0]      dflt_code_r;
  logic                  kind_r;
  logic [7:0]            byte_r;
  logic [ROOM_COUNT-1:0] match_r, match_nxt;
  logic [SLOT_W-1:0]     cur_r, cur_nxt;
  logic [CODE_W-1:0]     entry_r, entry_shift;
  logic [CFG_EXT_W-1:0]  dflt_ext;
  logic [CODE_W-1:0]     dflt_code;
  logic [SLOT_W-1:0]     found_idx;
  logic [1:0]            st_out;
  logic                  open_out;
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  // Default code fitted to the code width
  assign dflt_ext  = CFG_EXT_W'(dflt_code_r);
  assign dflt_code = dflt_ext[CODE_W-1:0];

  // Compare the incoming byte with every room number
  always_comb begin
    for (int k = 0; k < ROOM_COUNT; k++) begin
      match_nxt[k] = (room_num_r[k] == in_byte);
    end
  end

  // Lowest matching slot
  always_comb begin
    found_idx = '0;
    for (int k = ROOM_COUNT - 1; k >= 0; k--) begin
      if (match_r[k]) found_idx = SLOT_W'(k);
    end
  end

  assign entry_shift = CODE_W'({entry_r, byte_r});

  always_comb begin
    if (cmd.load_en)        cur_nxt = cmd.load_idx;
    else if (cmd.sel_found) cur_nxt = found_idx;
    else                    cur_nxt = cur_r;
  end

  // Room view after this word's writes
  assign st_out   = cmd.rs_wr ? cmd.rs_val : room_st_r[cur_nxt];
  assign open_out = cmd.ro_wr ? cmd.ro_val : room_open_r[cur_nxt];

  assign sts.kind       = kind_r;
  assign sts.data_byte  = byte_r;
  assign sts.found      = |match_r;
  assign sts.code_match = (entry_shift == room_code_r[cur_r]);
  assign sts.out_free   = !out_valid_r || out_tready;

  // Word capture and table contents; no reset needed
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r  <= in_kind;
      byte_r  <= in_byte;
      match_r <= match_nxt;
    end
    if (cmd.load_en) begin
      room_num_r[cmd.load_idx]  <= byte_r;
      room_code_r[cmd.load_idx] <= dflt_code;
    end else if (cmd.code_wr) begin
      room_code_r[cur_r] <= entry_shift;
    end
    if (cmd.commit) begin
      out_data_r <= {2'b00, cmd.err, cmd.phase, open_out, st_out, 4'(cur_nxt), cmd.led};
    end
  end

  // Room states, flags, slot pointer, entry buffer, default code, result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < ROOM_COUNT; k++) begin
        room_st_r[k]   <= ROOM_EMPTY;
        room_open_r[k] <= 1'b0;
      end
      cur_r       <= '0;
      entry_r     <= '0;
      dflt_code_r <= DEFAULT_CODE_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.rs_wr) room_st_r[cur_nxt] <= cmd.rs_val;
      if (cmd.ro_wr) room_open_r[cur_nxt] <= cmd.ro_val;
      cur_r <= cur_nxt;
      if (cmd.entry_clr)      entry_r <= '0;
      else if (cmd.key_shift) entry_r <= entry_shift;
      if (cfg_wr_en) dflt_code_r <= cfg_wr_data;
      if (cmd.commit)      out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> sv/multi_room_keypad_code_lock.sv
// Top level of the multi-room keypad code lock: controller plus datapath.
// Depends on mrkcl_pkg, mrkcl_ctrl and mrkcl_dp.
//
//  port group | dir | payload
//  in_*       | in  | tuser: opcode; tdata: data_byte
//  out_*      | out | tdata: led_drive, room_slot, room_status, door_open,
//             |     |        phase, error_code
//  cfg_*      | in  | wr_data: default_code
//
// Each word is taken in first, with its room match vector registered, and is
// then applied, which loads the result register once that register is free.
// Reset (rst_n low, synchronous) leaves the lock in the loading phase with all
// rooms empty and closed; room numbers and codes are filled by loading.
// A result waiting in the output register does not block the next input word;
// the apply cycle holds until that register is free.
`timescale 1ns / 1ps
module multi_room_keypad_code_lock (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic                              in_tuser,   // [0] opcode
  input  logic [7:0]                        in_tdata,   // [7:0] data_byte
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [1:0] led_drive, [5:2] room_slot, [7:6] room_status, [8] door_open,
  // [11:9] phase, [13:12] error_code, [15:14] zero
  output logic [mrkcl_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                              cfg_wr_en,
  input  logic [mrkcl_pkg::CFG_W-1:0]       cfg_wr_data  // default_code
);
  import mrkcl_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  mrkcl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mrkcl_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_kind     (in_tuser),
    .in_byte     (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_tdata   (out_tdata),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

>>> verif/tb_multi_room_keypad_code_lock.sv
// Self-checking bench for the multi-room keypad code lock: loads the room table,
// then drives commands, rooms and keypad groups while predicting every result.
// Depends on mrkcl_pkg and multi_room_keypad_code_lock.
`timescale 1ns / 1ps
module tb_multi_room_keypad_code_lock;
  import mrkcl_pkg::*;

  typedef enum logic [1:0] {
    ACT_WORD,
    ACT_CFG
  } plan_act_e;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_RANDOM,
    RX_THIRD,
    RX_SLOW
  } rx_mode_e;

  // One planned step: an input word, or a code register write made while idle
  typedef struct packed {
    plan_act_e  act;
    logic       opcode;
    logic [7:0] data_v;
    logic [31:0] cfg_v;
  } plan_t;

  // Status reported for one word
  typedef struct packed {
    logic [1:0]        led;
    logic [SLOT_W-1:0] slot;
    logic [1:0]        status;
    logic              open;
    phase_t            ph;
    logic [1:0]        err;
  } lock_status_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic in_tuser = 1'b0;          // [0] opcode
  logic [7:0] in_tdata = 8'h00;   // [7:0] data_byte
  logic out_tvalid;
  logic out_tready = 1'b0;
  // [1:0] led_drive, [5:2] room_slot, [7:6] room_status, [8] door_open,
  // [11:9] phase, [13:12] error_code
  logic [OUT_DATA_W-1:0] out_tdata;
  logic cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;

  plan_t        word_plan[$];
  lock_status_t status_due[$];
  int           mismatch_cnt = 0;
  int           useful_words = 0;

  // Lock state as the bench sees it; room states and flags start empty and closed
  logic [7:0]        lk_num[ROOM_COUNT];
  logic [CODE_W-1:0] lk_code[ROOM_COUNT];
  logic [1:0]        lk_state[ROOM_COUNT] = '{default: 2'b00};
  logic              lk_open[ROOM_COUNT] = '{default: 1'b0};
  phase_t            lk_phase = PH_LOAD;
  int                lk_loaded = 0;
  logic [1:0]        lk_cmd = CMD_EMPTY;
  logic [SLOT_W-1:0] lk_slot = '0;
  int                lk_keys = 0;
  logic [CODE_W-1:0] lk_entry = '0;
  logic [CFG_W-1:0]  lk_default = DEFAULT_CODE_RST;

  // Sender pacing
  int gap_left = 0;
  int burst_left = 0;
  int quiet = 0;

  // Receiver pacing
  rx_mode_e rx_mode = RX_FREE;
  int rx_left = 0;
  int rx_tick = 0;

  multi_room_keypad_code_lock dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Advance the lock by one word and return the status it should report
  function automatic lock_status_t lock_after_word(input logic kind, input logic [7:0] b);
    lock_status_t r;
    int hit;
    int k;
    r.led = LED_NONE;
    r.err = ERR_NONE;
    case (lk_phase)
      PH_LOAD: begin
        if (kind == KIND_SERIAL && lk_loaded < ROOM_COUNT) begin
          lk_num[lk_loaded]   = b;
          lk_code[lk_loaded]  = CODE_W'(lk_default);
          lk_state[lk_loaded] = ROOM_EMPTY;
          lk_open[lk_loaded]  = 1'b0;
          lk_slot = SLOT_W'(lk_loaded);
          lk_loaded++;
          if (lk_loaded >= ROOM_COUNT) lk_phase = PH_CMD;
        end
      end
      PH_CMD: begin
        if (kind == KIND_SERIAL) begin
          if (b <= CMD_MAX) begin
            lk_cmd = b[1:0];
            lk_phase = PH_ROOM;
          end else begin
            r.err = ERR_BAD_CMD;
          end
        end
      end
      PH_ROOM: begin
        if (kind == KIND_SERIAL) begin
          // lowest slot wins on duplicate numbers
          hit = -1;
          for (k = ROOM_COUNT - 1; k >= 0; k--)
            if (lk_num[k] == b) hit = k;
          if (hit < 0) begin
            r.err = ERR_NO_ROOM;
            lk_phase = PH_CMD;
          end else begin
            lk_slot = SLOT_W'(hit);
            case (lk_cmd)
              CMD_EMPTY: begin
                lk_state[hit] = ROOM_EMPTY;
                lk_open[hit]  = 1'b0;
                r.led = LED_RED;
                lk_phase = PH_CMD;
              end
              CMD_CLEAN: begin
                lk_state[hit] = ROOM_CLEANING;
                lk_open[hit]  = 1'b1;
                r.led = LED_BLUE;
                lk_phase = PH_CMD;
              end
              CMD_RESERVE: begin
                lk_keys  = 0;
                lk_entry = '0;
                lk_phase = PH_NEW;
              end
              default: ;
            endcase
          end
        end
      end
      PH_NEW, PH_VERIFY: begin
        if (kind == KIND_KEY && b != NO_KEY) begin
          lk_entry = {lk_entry[CODE_W-9:0], b};
          lk_keys++;
          if (lk_keys >= CODE_LENGTH) begin
            lk_keys = 0;
            if (lk_phase == PH_NEW) begin
              lk_code[lk_slot]  = lk_entry;
              lk_state[lk_slot] = ROOM_RESERVED;
              lk_open[lk_slot]  = 1'b0;
              r.led = LED_RED;
              lk_phase = PH_VERIFY;
            end else if (lk_entry == lk_code[lk_slot]) begin
              lk_open[lk_slot] = 1'b1;
              r.led = LED_BLUE;
              lk_phase = PH_CMD;
            end
            lk_entry = '0;
          end
        end
      end
      default: lk_phase = PH_LOAD;
    endcase
    r.slot   = lk_slot;
    r.status = lk_state[lk_slot];
    r.open   = lk_open[lk_slot];
    r.ph     = lk_phase;
    return r;
  endfunction

  // Sender: hold a word until taken, pace in bursts, write the code register when idle
  always @(posedge clk) begin : send_p
    plan_t nxt;
    logic  cfg_we;
    cfg_we = 1'b0;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_left = 0;
      burst_left = 0;
      quiet = 0;
    end else begin
      if (in_tvalid && in_tready)
        status_due.push_back(lock_after_word(in_tuser, in_tdata));
      if (in_tvalid && !in_tready) begin
        // hold the word
      end else if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (word_plan.size() == 0) begin
        in_tvalid <= 1'b0;
      end else if (word_plan[0].act == ACT_WORD) begin
        nxt = word_plan.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= nxt.opcode;
        in_tdata  <= nxt.data_v;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        end else begin
          burst_left--;
        end
      end else begin
        // wait for every result to drain before touching the register
        in_tvalid <= 1'b0;
        if (status_due.size() == 0) quiet++;
        else quiet = 0;
        if (quiet >= 4) begin
          nxt = word_plan.pop_front();
          quiet = 0;
          cfg_we = 1'b1;
          cfg_wr_data <= nxt.cfg_v;
          lk_default = nxt.cfg_v;
        end
      end
    end
    cfg_wr_en <= cfg_we;
  end

  // Receiver: stall on a changing pattern and check each result word
  always @(posedge clk) begin : recv_p
    lock_status_t want;
    lock_status_t got;
    logic rdy;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.led    = out_tdata[1:0];
        got.slot   = out_tdata[5:2];
        got.status = out_tdata[7:6];
        got.open   = out_tdata[8];
        got.ph     = phase_t'(out_tdata[11:9]);
        got.err    = out_tdata[13:12];
        if (status_due.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected result word %h at %0t", out_tdata, $realtime);
        end else begin
          want = status_due.pop_front();
          if (got.led !== want.led || got.slot !== want.slot ||
              got.status !== want.status || got.open !== want.open ||
              got.ph !== want.ph || got.err !== want.err) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $write("mismatch at %0t: led %0d/%0d slot %0d/%0d status %0d/%0d ",
                     $realtime, want.led, got.led, want.slot, got.slot,
                     want.status, got.status);
              $display("open %0d/%0d phase %0d/%0d err %0d/%0d (expected/actual)",
                       want.open, got.open, want.ph, got.ph, want.err, got.err);
            end
          end
        end
      end
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_left = $urandom_range(20, 120);
      end else begin
        rx_left--;
      end
      rx_tick++;
      case (rx_mode)
        RX_FREE:   rdy = 1'b1;
        RX_RANDOM: rdy = ($urandom_range(0, 3) != 0);
        RX_THIRD:  rdy = (rx_tick % 3 == 0);
        default:   rdy = (rx_tick % 16 == 0);
      endcase
      out_tready <= rdy;
    end
  end

  task automatic add_word(input logic op, input logic [7:0] d, input bit noise = 1'b0);
    plan_t p;
    p.act = ACT_WORD;
    p.opcode = op;
    p.data_v = d;
    p.cfg_v = '0;
    word_plan.push_back(p);
    if (!noise) useful_words++;
  endtask

  task automatic add_cfg(input logic [31:0] v);
    plan_t p;
    p.act = ACT_CFG;
    p.opcode = KIND_SERIAL;
    p.data_v = '0;
    p.cfg_v = v;
    word_plan.push_back(p);
  endtask

  // Push one group of keys, first key from the top byte, with optional stray words
  task automatic add_group(input logic [CODE_W-1:0] code, input bit noisy);
    int i;
    for (i = CODE_LENGTH - 1; i >= 0; i--) begin
      if (noisy && $urandom_range(0, 7) == 0) begin
        if ($urandom_range(0, 1) == 0) add_word(KIND_KEY, NO_KEY, 1'b1);
        else add_word(KIND_SERIAL, 8'($urandom), 1'b1);
      end
      add_word(KIND_KEY, code[8*i +: 8]);
    end
  endtask

  // Random key that can be entered: never the no-key mark
  function automatic logic [7:0] pick_key();
    logic [7:0] k;
    if ($urandom_range(0, 2) != 0) k = 8'h30 + 8'($urandom_range(0, 9));
    else k = 8'($urandom);
    if (k == NO_KEY) k = k ^ 8'h01;
    return k;
  endfunction

  // Stimulus, run control and end of test
  initial begin : run_p
    logic [7:0]        rooms[ROOM_COUNT];
    logic [CODE_W-1:0] code;
    logic [CODE_W-1:0] wrong;
    logic [31:0]       cfg_set[4];
    logic [7:0]        b;
    int                cfg_ix;
    int                next_write;
    int                pick;
    int                n;
    int                j;
    int                bit_ix;
    bit                known;

    rooms = '{8'h00, 8'hFF, 8'h01, 8'h02, 8'h55, 8'hAA, 8'h10, 8'h20,
              8'h30, 8'h40, 8'h50, 8'h60, 8'h70, 8'h80, 8'h55, 8'h78};
    cfg_set = '{32'h0000_0000, 32'hFFFF_FFFF, DEFAULT_CODE_RST, $urandom};

    // Load the table; a key during loading must be ignored
    add_cfg($urandom);
    add_word(KIND_KEY, 8'h31);
    foreach (rooms[i]) add_word(KIND_SERIAL, rooms[i]);

    // Bad commands, a stray key, each command, unknown and duplicate rooms
    add_word(KIND_SERIAL, 8'hFF);
    add_word(KIND_SERIAL, 8'h03);
    add_word(KIND_KEY, 8'h35);
    add_word(KIND_SERIAL, 8'(CMD_EMPTY));
    add_word(KIND_SERIAL, 8'hFF);
    add_word(KIND_SERIAL, 8'(CMD_CLEAN));
    add_word(KIND_SERIAL, 8'h55);
    add_word(KIND_SERIAL, 8'(CMD_RESERVE));
    add_word(KIND_SERIAL, 8'h42);
    add_word(KIND_SERIAL, 8'(CMD_RESERVE));
    add_word(KIND_SERIAL, 8'h00);
    // serial byte while collecting, no-key mark inside the new code "1234"
    add_word(KIND_SERIAL, 8'h33);
    add_word(KIND_KEY, 8'h31);
    add_word(KIND_KEY, NO_KEY);
    add_word(KIND_KEY, 8'h32);
    add_word(KIND_KEY, 8'h33);
    add_word(KIND_KEY, 8'h34);
    // wrong group "1235", then the right one
    add_group(32'h3132_3335, 1'b0);
    add_group(32'h3132_3334, 1'b0);

    // Random sessions, mostly well formed
    cfg_ix = 0;
    next_write = 200;
    while (useful_words < 1050) begin
      if (useful_words >= next_write) begin
        add_cfg(cfg_set[cfg_ix % 4]);
        cfg_ix++;
        next_write += 200;
      end
      if ($urandom_range(0, 9) == 0) add_word(KIND_KEY, 8'($urandom), 1'b1);
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        // reserve: new code, a few wrong groups, then the right one
        add_word(KIND_SERIAL, 8'(CMD_RESERVE));
        if ($urandom_range(0, 7) == 0) add_word(KIND_KEY, 8'($urandom), 1'b1);
        add_word(KIND_SERIAL, rooms[$urandom_range(0, ROOM_COUNT - 1)]);
        for (j = 0; j < CODE_LENGTH; j++) code[8*j +: 8] = pick_key();
        add_group(code, 1'b1);
        n = $urandom_range(0, 3);
        repeat (n) begin
          if ($urandom_range(0, 1) == 0) begin
            for (j = 0; j < CODE_LENGTH; j++) wrong[8*j +: 8] = pick_key();
          end else begin
            // near miss: one bit of one key flipped
            wrong = code;
            j = $urandom_range(0, CODE_LENGTH - 1);
            do begin
              bit_ix = $urandom_range(0, 7);
              b = code[8*j +: 8] ^ (8'h01 << bit_ix);
            end while (b == NO_KEY);
            wrong[8*j +: 8] = b;
          end
          add_group(wrong, 1'b1);
        end
        add_group(code, 1'b1);
      end else if (pick < 70) begin
        add_word(KIND_SERIAL, 8'(($urandom_range(0, 1) == 0) ? CMD_EMPTY : CMD_CLEAN));
        add_word(KIND_SERIAL, rooms[$urandom_range(0, ROOM_COUNT - 1)]);
      end else if (pick < 82) begin
        // command to a room that is not in the table
        add_word(KIND_SERIAL, 8'($urandom_range(0, 2)));
        do begin
          b = 8'($urandom);
          known = 1'b0;
          foreach (rooms[i]) if (rooms[i] == b) known = 1'b1;
        end while (known);
        add_word(KIND_SERIAL, b);
      end else begin
        add_word(KIND_SERIAL, 8'($urandom_range(3, 255)));
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (!(word_plan.size() == 0 && !in_tvalid && status_due.size() == 0))
      @(posedge clk);
    repeat (12) @(posedge clk);
    if (mismatch_cnt == 0 && status_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: 5 ms is far beyond the slowest legal run
  initial begin : watchdog_p
    #(5_000_000);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
